[sv/sorted_table_bound_search_unit_macros.svh]
// assertion macros for the bound search unit
`ifndef SORTED_TABLE_BOUND_SEARCH_UNIT_MACROS_SVH
`define SORTED_TABLE_BOUND_SEARCH_UNIT_MACROS_SVH

// holds at every clock edge outside reset
`define STB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define STB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/stbs_pkg.sv]
// ----------------------------------------------------------------------------
// stbs_pkg
// shared types, constants and compare helper of the bound search unit
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TableDepth = 1024;
  localparam int KeyW       = 32;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int PosW       = $clog2(TableDepth + 1);
  localparam int Steps      = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_LOWER = 2'd1,
    KIND_UPPER = 2'd2,
    KIND_FIND  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [IdxW-1:0] entry_index;
    logic [31:0]     key_value;
  } req_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic            found;
  } rsp_t;

  // one item as it moves down the pipeline
  typedef struct packed {
    logic            valid;
    kind_t           kind;
    logic [IdxW-1:0] idx;
    logic [KeyW-1:0] key;
    logic [PosW-1:0] lo;
    logic [PosW-1:0] hi;
    logic [PosW-1:0] span;
  } item_t;

  function automatic logic key_less(logic [KeyW-1:0] a, logic [KeyW-1:0] b,
                                    logic sgn);
    logic [KeyW-1:0] fa;
    logic [KeyW-1:0] fb;
    fa = a ^ {sgn, {(KeyW-1){1'b0}}};
    fb = b ^ {sgn, {(KeyW-1){1'b0}}};
    return fa < fb;
  endfunction

endpackage

[sv/sorted_table_bound_search_unit.sv]
// ----------------------------------------------------------------------------
// sorted_table_bound_search_unit
// lower bound, upper bound and exact find over a table of sorted keys
// ----------------------------------------------------------------------------
// One item enters per cycle unless the pipeline holds. A query passes 24 register
// stages: eleven halving steps, each reading its own copy of the table once,
// then the final entry check. The first stage loads at the transfer edge itself.
// Write items travel the same pipeline, updating each copy as they pass, so
// a query sees exactly the writes accepted before it; writes give no result.
// The whole pipeline holds while a result waits under stall.
module sorted_table_bound_search_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  stbs_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output stbs_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic [stbs_pkg::PosW-1:0] used_length;
  logic                      compare_signed;
  logic                      en;
  stbs_pkg::item_t           chain [stbs_pkg::Steps+1];
  logic [stbs_pkg::PosW-1:0] span;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_length    <= '0;
      compare_signed <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        compare_signed <= pwdata[0];
      end else begin
        used_length <= pwdata[stbs_pkg::PosW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2]) begin
      prdata[0] = compare_signed;
    end else begin
      prdata[stbs_pkg::PosW-1:0] = used_length;
    end
  end

  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  // searched range saturates at the table depth
  assign span = (used_length > stbs_pkg::PosW'(stbs_pkg::TableDepth)) ?
                stbs_pkg::PosW'(stbs_pkg::TableDepth) : used_length;

  always_comb begin
    chain[0].valid = req_valid;
    chain[0].kind  = stbs_pkg::kind_t'(req.kind);
    chain[0].idx   = req.entry_index;
    chain[0].key   = req.key_value[stbs_pkg::KeyW-1:0];
    chain[0].lo    = '0;
    chain[0].hi    = span;
    chain[0].span  = span;
  end

  for (genvar g = 0; g < stbs_pkg::Steps; g++) begin : g_step
    stbs_step u_step (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .cmp_signed (compare_signed),
      .din        (chain[g]),
      .dout       (chain[g+1])
    );
  end

  stbs_find u_find (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .din        (chain[stbs_pkg::Steps]),
    .dout_valid (rsp_valid),
    .dout       (rsp)
  );

endmodule

[sv/stbs_step.sv]
// ----------------------------------------------------------------------------
// stbs_step
// one halving step: table copy read at the midpoint, then narrow lo or hi
// ----------------------------------------------------------------------------
module stbs_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            cmp_signed,
  input  stbs_pkg::item_t din,
  output stbs_pkg::item_t dout
);

  logic [stbs_pkg::KeyW-1:0] mem [stbs_pkg::TableDepth];
  logic [stbs_pkg::KeyW-1:0] rdata;
  stbs_pkg::item_t           item_a;
  stbs_pkg::item_t           dout_next;
  logic [stbs_pkg::PosW-1:0] mid;
  logic [stbs_pkg::PosW-1:0] mid_a;
  logic                      go_right;

  assign mid = din.lo + ((din.hi - din.lo) >> 1);

  // write items update this copy as they pass, keeping program order
  always_ff @(posedge clk) begin
    if (en) begin
      if (din.valid && din.kind == stbs_pkg::KIND_WRITE) begin
        mem[din.idx] <= din.key;
      end
      rdata <= mem[mid[stbs_pkg::IdxW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_a.valid <= 1'b0;
      dout.valid   <= 1'b0;
    end else if (en) begin
      item_a <= din;
      dout   <= dout_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_a <= mid;
    end
  end

  always_comb begin
    go_right = stbs_pkg::key_less(rdata, item_a.key, cmp_signed) ||
               (item_a.kind == stbs_pkg::KIND_UPPER && rdata == item_a.key);
    dout_next = item_a;
    if (item_a.kind != stbs_pkg::KIND_WRITE && item_a.lo < item_a.hi) begin
      if (go_right) begin
        dout_next.lo = mid_a + stbs_pkg::PosW'(1);
      end else begin
        dout_next.hi = mid_a;
      end
    end
  end

endmodule

[sv/stbs_find.sv]
// ----------------------------------------------------------------------------
// stbs_find
// final stage: reads the entry at the bound and forms the result
// ----------------------------------------------------------------------------
module stbs_find (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  stbs_pkg::item_t din,
  output logic            dout_valid,
  output stbs_pkg::rsp_t  dout
);

  logic [stbs_pkg::KeyW-1:0] mem [stbs_pkg::TableDepth];
  logic [stbs_pkg::KeyW-1:0] rdata;
  stbs_pkg::item_t           item_a;
  stbs_pkg::rsp_t            dout_next;

  always_ff @(posedge clk) begin
    if (en) begin
      if (din.valid && din.kind == stbs_pkg::KIND_WRITE) begin
        mem[din.idx] <= din.key;
      end
      rdata <= mem[din.lo[stbs_pkg::IdxW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_a.valid <= 1'b0;
      dout_valid   <= 1'b0;
    end else if (en) begin
      item_a     <= din;
      dout_valid <= item_a.valid && item_a.kind != stbs_pkg::KIND_WRITE;
      dout       <= dout_next;
    end
  end

  always_comb begin
    dout_next.position = item_a.lo;
    dout_next.found    = item_a.kind == stbs_pkg::KIND_FIND &&
                         item_a.lo < item_a.span && rdata == item_a.key;
  end

endmodule

[sv/stbs_checker.sv]
// ----------------------------------------------------------------------------
// stbs_checker
// port-level checks of the bound search unit, bound to the top level
// ----------------------------------------------------------------------------
`include "sorted_table_bound_search_unit_macros.svh"

module stbs_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input stbs_pkg::rsp_t rsp
);

  `STB_ASSERT(a_stall_only_on_blocked_result, req_stall == (rsp_valid && rsp_stall), "input stall without a blocked result")
  `STB_ASSERT(a_found_inside_table, !rsp_valid || !rsp.found || !rsp.position[stbs_pkg::PosW-1], "found reported past the table end")
  `STB_ASSERT_NEXT(a_valid_holds, rsp_valid && rsp_stall, rsp_valid, "result dropped under stall")
  `STB_ASSERT_NEXT(a_payload_holds, rsp_valid && rsp_stall, $stable(rsp), "result changed under stall")

endmodule

bind sorted_table_bound_search_unit stbs_checker u_stbs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
